@@ rtl/drc_pkg.sv @@
// Package for the disturbance rejection controller: default clamp limits,
// sequencer step codes and saturating Q32.32 helpers. No dependencies.
package drc_pkg;

    localparam int DefOutHigh = 1;
    localparam int DefOutLow  = -1;

    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TS    = 3'd0,
        REG_B     = 3'd1,
        REG_BINV  = 3'd2,
        REG_BETA1 = 3'd3,
        REG_BETA2 = 3'd4,
        REG_KP    = 3'd5,
        REG_LZ    = 3'd6,
        REG_LZG   = 3'd7
    } t_reg;

    // Sequencer step codes.
    typedef enum logic [3:0] {
        OP_E, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_T,
        OP_FAL, OP_RT, OP_LF, OP_M7, OP_V, OP_FRC
    } t_op;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? SMIN : SMAX;
        end
        return s;
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
            return a[63] ? SMIN : SMAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

endpackage

@@ rtl/disturbance_rejection_controller_unit.sv @@
// Disturbance rejection controller, top level: sequencer, bit-serial
// multiplier and bit-serial square root. Depends on drc_pkg.
// A run item passes eleven sequencing steps with eight bit-serial multiplies in the
// linear zone, or seven multiplies and a bit-serial square root when the root branch
// is taken. A force item holds the input while its single multiply runs. One item is
// in work at a time, so the next item is taken only once the last one is through; a
// drive still waiting in the output register holds the next run item in its last
// step. Synchronous active-low reset clears the coefficients, the controller state
// and the handshake flags; no clearing pass.
module disturbance_rejection_controller_unit
    import drc_pkg::*;
#(
    parameter int OUT_HIGH = DefOutHigh,
    parameter int OUT_LOW  = DefOutLow
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_kind,
    input  logic signed [63:0] i_setpoint,
    input  logic signed [63:0] i_measurement,
    input  logic signed [63:0] i_force_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_drive,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    // Clamp limits in Q32.32.
    localparam logic signed [63:0] HIGH_Q = 64'(longint'(OUT_HIGH) * 64'sd4294967296);
    localparam logic signed [63:0] LOW_Q  = 64'(longint'(OUT_LOW) * 64'sd4294967296);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_MUL  = 4'b0100,
        S_ROOT = 4'b1000
    } t_state;

    t_state r_state;
    t_op    r_op;

    // Coefficients.
    logic signed [63:0] r_ts, r_b, r_binv, r_beta1, r_beta2, r_kp;
    logic [62:0]        r_lz, r_lzg;

    // Controller state and per-item working values.
    logic signed [63:0] r_pos, r_dist, r_last;
    logic               r_primed;
    logic signed [63:0] r_sp, r_meas, r_err, r_pnew, r_trk;

    // Serial multiplier: magnitudes are multiplied one bit per cycle.
    logic [63:0]  r_ma, r_mb;
    logic         r_mneg;
    logic [127:0] r_prod;
    logic [6:0]   r_cnt;
    logic [64:0]  mul_sum;
    logic signed [63:0] mres;

    // Serial square root: two radicand bits per cycle, one root bit out.
    logic [95:0]  r_rx;
    logic [51:0]  r_rem;
    logic [47:0]  r_root;
    logic [51:0]  rt_shift, rt_trial;

    logic               r_ovalid;
    logic signed [63:0] r_drive;

    logic               in_acc;
    logic signed [63:0] sv, l_a, l_b;
    logic               launch, go_root;
    logic               deliver;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_drive     = r_drive;
    assign in_acc      = i_valid && !o_stall;

    // The clamped drive moves to the output register once that register is free.
    assign deliver = (r_state == S_STEP) && (r_op == OP_V) && (!r_ovalid || !i_stall);

    assign mul_sum  = {1'b0, r_prod[127:64]} + (r_mb[0] ? {1'b0, r_ma} : 65'd0);
    assign rt_shift = {r_rem[49:0], r_rx[95:94]};
    assign rt_trial = {2'b00, r_root, 2'b01};

    // Saturating result of the finished product, shifted right by 32.
    always_comb begin
        if (!r_mneg) begin
            mres = ((|r_prod[127:96]) || r_prod[95]) ? SMAX : r_prod[95:32];
        end else begin
            mres = ((|r_prod[127:96]) || r_prod[95]) ? SMIN : (64'sd0 - r_prod[95:32]);
        end
    end

    // One sequencer step of a run or force item: a single add, select or clamp, then,
    // where the step launches one, the operands of the next multiply or the square root.
    always_comb begin
        sv      = mres;
        l_a     = r_kp;
        l_b     = r_err;
        launch  = 1'b0;
        go_root = 1'b0;
        case (r_op)
            OP_E: begin
                sv = ssub(r_pos, r_meas);
                l_a = r_ts; l_b = r_dist; launch = 1'b1;
            end
            OP_M1: begin
                sv = sadd(r_pos, mres);
                l_a = r_beta1; l_b = r_err; launch = 1'b1;
            end
            OP_M2: begin
                sv = ssub(r_pnew, mres);
                l_a = r_ts; l_b = r_b; launch = 1'b1;
            end
            OP_M3: begin
                sv = mres;
                l_a = mres; l_b = r_last; launch = 1'b1;
            end
            OP_M4: begin
                sv = sadd(r_pnew, mres);
                l_a = r_beta2; l_b = r_err; launch = 1'b1;
            end
            OP_M5: sv = ssub(r_dist, mres);
            OP_T:  sv = ssub(r_sp, r_pnew);
            OP_FAL: begin
                if (mag(r_trk) >= {1'b0, r_lz}) begin
                    go_root = 1'b1;
                end else begin
                    l_a = {1'b0, r_lzg}; l_b = r_trk; launch = 1'b1;
                end
            end
            OP_RT: begin
                sv = r_trk[63] ? (64'sd0 - {16'd0, r_root}) : {16'd0, r_root};
                l_a = r_kp; l_b = sv; launch = 1'b1;
            end
            OP_LF: begin
                sv = mres;
                l_a = r_kp; l_b = mres; launch = 1'b1;
            end
            OP_M7: begin
                sv = ssub(mres, r_dist);
                l_a = r_binv; l_b = sv; launch = 1'b1;
            end
            OP_V: begin
                if (mres > HIGH_Q) begin
                    sv = HIGH_Q;
                end else if (mres < LOW_Q) begin
                    sv = LOW_Q;
                end
            end
            OP_FRC: sv = ssub(64'sd0, mres);
            default: sv = mres;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_E;
            r_ts     <= '0; r_b     <= '0; r_binv <= '0;
            r_beta1  <= '0; r_beta2 <= '0; r_kp   <= '0;
            r_lz     <= '0; r_lzg   <= '0;
            r_pos    <= '0; r_dist  <= '0; r_last <= '0;
            r_primed <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (deliver) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TS:    r_ts    <= i_cfg_data;
                    REG_B:     r_b     <= i_cfg_data;
                    REG_BINV:  r_binv  <= i_cfg_data;
                    REG_BETA1: r_beta1 <= i_cfg_data;
                    REG_BETA2: r_beta2 <= i_cfg_data;
                    REG_KP:    r_kp    <= i_cfg_data;
                    REG_LZ:    r_lz    <= i_cfg_data[62:0];
                    REG_LZG:   r_lzg   <= i_cfg_data[62:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_kind) begin
                            // Force: preset the drive, then form -(b * u0).
                            r_last   <= i_force_value;
                            r_primed <= 1'b0;
                            r_ma     <= mag(r_b);
                            r_mb     <= mag(i_force_value);
                            r_mneg   <= r_b[63] ^ i_force_value[63];
                            r_prod   <= '0;
                            r_cnt    <= 7'd64;
                            r_op     <= OP_FRC;
                            r_state  <= S_MUL;
                        end else begin
                            r_sp   <= i_setpoint;
                            r_meas <= i_measurement;
                            if (!r_primed) begin
                                r_pos    <= i_measurement;
                                r_primed <= 1'b1;
                            end
                            r_op    <= OP_E;
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    case (r_op)
                        OP_E:  r_err  <= sv;
                        OP_M1, OP_M2, OP_M4: r_pnew <= sv;
                        OP_M5: begin
                            r_dist <= sv;
                            r_pos  <= r_pnew;
                        end
                        OP_T:  r_trk  <= sv;
                        default: ;
                    endcase

                    if (launch) begin
                        r_ma    <= mag(l_a);
                        r_mb    <= mag(l_b);
                        r_mneg  <= l_a[63] ^ l_b[63];
                        r_prod  <= '0;
                        r_cnt   <= 7'd64;
                        r_state <= S_MUL;
                    end else if (go_root) begin
                        r_rx    <= {mag(r_trk), 32'd0};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= 7'd48;
                        r_state <= S_ROOT;
                    end

                    case (r_op)
                        OP_E:   r_op <= OP_M1;
                        OP_M1:  r_op <= OP_M2;
                        OP_M2:  r_op <= OP_M3;
                        OP_M3:  r_op <= OP_M4;
                        OP_M4:  r_op <= OP_M5;
                        OP_M5:  r_op <= OP_T;
                        OP_T:   r_op <= OP_FAL;
                        OP_FAL: r_op <= go_root ? OP_RT : OP_LF;
                        OP_RT, OP_LF: r_op <= OP_M7;
                        OP_M7:  r_op <= OP_V;
                        OP_V: begin
                            // Deliver only once the output register is free.
                            if (deliver) begin
                                r_last   <= sv;
                                r_drive  <= sv;
                                r_state  <= S_IDLE;
                            end
                        end
                        OP_FRC: begin
                            r_dist  <= sv;
                            r_state <= S_IDLE;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_MUL: begin
                    r_prod <= {mul_sum, r_prod[63:1]};
                    r_mb   <= {1'b0, r_mb[63:1]};
                    r_cnt  <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_STEP;
                    end
                end
                S_ROOT: begin
                    if (rt_shift >= rt_trial) begin
                        r_rem  <= rt_shift - rt_trial;
                        r_root <= {r_root[46:0], 1'b1};
                    end else begin
                        r_rem  <= rt_shift;
                        r_root <= {r_root[46:0], 1'b0};
                    end
                    r_rx  <= {r_rx[93:0], 2'b00};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_STEP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/drc_checker.sv @@
// Port-level checker for the disturbance rejection controller and its bind.
// Depends on drc_pkg and disturbance_rejection_controller_unit.
module drc_checker
    import drc_pkg::*;
#(
    parameter int OUT_HIGH = DefOutHigh
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [63:0] o_drive
);

    localparam logic signed [63:0] HIGH_Q = 64'(longint'(OUT_HIGH) * 64'sd4294967296);

    // A pending item stays offered while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive))
        else $error("drive item dropped or changed under stall");

    // Reset leaves no result pending and the input open.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("state not cleared by reset");

    // A valid drive never exceeds the upper clamp limit.
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_drive <= HIGH_Q)
        else $error("drive above upper limit");

    // A result cannot appear in the cycle right after an item is taken while none is pending.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind disturbance_rejection_controller_unit drc_checker #(
    .OUT_HIGH(OUT_HIGH)
) u_drc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_drive (o_drive)
);
